### sv/gif_stream_lzw_validator_defines.svh
// Assertion macros for the GIF stream validator.
// Used by the LZW code checker; expects clk_i and rst_ni in scope.
`ifndef GIF_STREAM_LZW_VALIDATOR_DEFINES_SVH
`define GIF_STREAM_LZW_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GSLV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gslv assertion failed");
`define GSLV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gslv assertion failed");
`else
`define GSLV_ASSERT(lbl, prop)
`define GSLV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/gslv_pkg.sv
// Shared types, constants and helpers of the GIF stream validator.
// No dependencies.
`default_nettype none
package gslv_pkg;

  localparam int unsigned CodeTableEntries = 4096;
  localparam int unsigned MaxCodeWidth     = 12;

  localparam logic [7:0] TrailerByte   = 8'h3b;
  localparam logic [7:0] ExtIntroByte  = 8'h21;
  localparam logic [7:0] ImageSepByte  = 8'h2c;
  localparam logic [7:0] Gif89VerByte  = 8'h39;
  localparam logic [15:0] MaxSeqLen    = 16'hffff;

  typedef enum logic [1:0] {
    LZW_RUNNING = 2'd0,
    LZW_OK      = 2'd1,
    LZW_FAILED  = 2'd2
  } lzw_status_e;

  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } lzw_cmd_t;

  typedef struct packed {
    logic        busy;
    lzw_status_e status;
  } lzw_stat_t;

  // Signature "GIF87a"; the version digit also accepts '9'
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h47;
      3'd1:    v = 8'h49;
      3'd2:    v = 8'h46;
      3'd3:    v = 8'h38;
      3'd4:    v = 8'h37;
      3'd5:    v = 8'h61;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Color table size in bytes: 3 * 2^(n+1)
  function automatic logic [9:0] table_bytes(input logic [7:0] flags);
    return 10'(10'd6 << flags[2:0]);
  endfunction

endpackage
`default_nettype wire

### sv/gslv_lzw.sv
// LZW code-length checker of the GIF stream validator.
// Depends on gslv_pkg and gif_stream_lzw_validator_defines.svh.
`default_nettype none
`include "gif_stream_lzw_validator_defines.svh"
module gslv_lzw
  import gslv_pkg::*;
#(
  parameter int unsigned CODE_TABLE_ENTRIES = CodeTableEntries
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lzw_cmd_t   cmd_i,
  input  wire logic [3:0] root_bits_i,
  input  wire logic [31:0] pix_expected_i,
  output lzw_stat_t       stat_o
);

  localparam int unsigned AddrW = $clog2(CODE_TABLE_ENTRIES);

  typedef enum logic [1:0] {L_IDLE, L_CODE, L_APPLY} lzw_state_e;

  lzw_state_e  state_q;
  lzw_status_e status_q;
  logic [19:0] buf_q;
  logic [4:0]  cnt_q;
  logic [3:0]  root_q;
  logic [3:0]  cw_q;
  logic [AddrW:0] nfc_q;
  logic        pv_q;
  logic [15:0] prev_len_q;
  logic [15:0] len_q;
  logic        use_mem_q;
  logic [31:0] counted_q;

  logic [15:0] mem [CODE_TABLE_ENTRIES];
  logic [15:0] rdata_q;
  logic        mem_we;
  logic        mem_re;
  logic [AddrW-1:0] rd_addr;

  logic [11:0] code_mask;
  logic [11:0] code;
  logic [AddrW:0] code_x;
  logic [AddrW:0] clear_code;
  logic [15:0] apply_len;
  logic [31:0] remaining;

  assign code_mask  = 12'((13'd1 << cw_q) - 13'd1);
  assign code       = buf_q[11:0] & code_mask;
  assign code_x     = (AddrW + 1)'(code);
  assign clear_code = (AddrW + 1)'(1) << root_q;
  assign apply_len  = use_mem_q ? rdata_q : len_q;
  assign remaining  = pix_expected_i - counted_q;
  assign rd_addr    = code_x[AddrW-1:0];
  assign mem_re     = (state_q == L_CODE) && (cnt_q >= {1'b0, cw_q}) &&
                      (code_x != clear_code) && (code_x != clear_code + 1'b1) &&
                      (code_x < nfc_q) && (code_x >= clear_code);
  assign mem_we     = (state_q == L_APPLY) && (apply_len <= remaining) && pv_q &&
                      (nfc_q < (AddrW + 1)'(CODE_TABLE_ENTRIES)) && (prev_len_q != MaxSeqLen);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[nfc_q[AddrW-1:0]] <= prev_len_q + 16'd1;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign stat_o.busy   = (state_q != L_IDLE);
  assign stat_o.status = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= L_IDLE;
      status_q   <= LZW_RUNNING;
      buf_q      <= '0;
      cnt_q      <= '0;
      root_q     <= '0;
      cw_q       <= '0;
      nfc_q      <= '0;
      pv_q       <= 1'b0;
      prev_len_q <= '0;
      len_q      <= '0;
      use_mem_q  <= 1'b0;
      counted_q  <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (cmd_i.init) begin
            root_q    <= root_bits_i;
            cw_q      <= root_bits_i + 4'd1;
            nfc_q     <= ((AddrW + 1)'(1) << root_bits_i) + (AddrW + 1)'(2);
            pv_q      <= 1'b0;
            counted_q <= '0;
            buf_q     <= '0;
            cnt_q     <= '0;
            status_q  <= LZW_RUNNING;
          end else if (cmd_i.start && status_q == LZW_RUNNING) begin
            buf_q   <= buf_q | (20'(cmd_i.data) << cnt_q);
            cnt_q   <= cnt_q + 5'd8;
            state_q <= L_CODE;
          end
        end
        L_CODE: begin
          if (cnt_q < {1'b0, cw_q}) begin
            state_q <= L_IDLE;
          end else begin
            // consume one code
            buf_q <= buf_q >> cw_q;
            cnt_q <= cnt_q - {1'b0, cw_q};
            use_mem_q <= 1'b0;
            priority if (code_x == clear_code) begin
              nfc_q <= clear_code + (AddrW + 1)'(2);
              cw_q  <= root_q + 4'd1;
              pv_q  <= 1'b0;
            end else if (code_x == clear_code + 1'b1) begin
              status_q <= (counted_q == pix_expected_i) ? LZW_OK : LZW_FAILED;
              state_q  <= L_IDLE;
            end else if (code_x < nfc_q) begin
              len_q     <= 16'd1;
              use_mem_q <= (code_x >= clear_code);
              state_q   <= L_APPLY;
            end else if (code_x == nfc_q && pv_q && prev_len_q != MaxSeqLen) begin
              len_q   <= prev_len_q + 16'd1;
              state_q <= L_APPLY;
            end else begin
              status_q <= LZW_FAILED;
              state_q  <= L_IDLE;
            end
          end
        end
        L_APPLY: begin
          if (apply_len > remaining) begin
            status_q <= LZW_FAILED;
            state_q  <= L_IDLE;
          end else begin
            counted_q <= counted_q + 32'(apply_len);
            if (pv_q && nfc_q < (AddrW + 1)'(CODE_TABLE_ENTRIES) && prev_len_q == MaxSeqLen) begin
              status_q <= LZW_FAILED;
              state_q  <= L_IDLE;
            end else begin
              if (mem_we) begin
                nfc_q <= nfc_q + 1'b1;
                if (cw_q < 4'(MaxCodeWidth) &&
                    (nfc_q + 1'b1) == ((AddrW + 1)'(1) << cw_q)) begin
                  cw_q <= cw_q + 4'd1;
                end
              end
              prev_len_q <= apply_len;
              pv_q       <= 1'b1;
              state_q    <= L_CODE;
            end
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  `GSLV_ASSERT(a_bit_count_bound, cnt_q <= 5'd19)
  `GSLV_ASSERT(a_free_code_bound, nfc_q <= (AddrW + 1)'(CODE_TABLE_ENTRIES))
  `GSLV_ASSERT(a_no_start_when_busy, cmd_i.start |-> state_q == L_IDLE)
  `GSLV_ASSERT_NEXT(a_apply_after_code, state_q == L_APPLY, state_q != L_APPLY)

endmodule
`default_nettype wire

### sv/gif_stream_lzw_validator.sv
// A non-data byte is parsed as it is accepted; a data byte goes to the LZW checker, which
// steps each code it completes (up to three) through L_CODE and L_APPLY. Outside image
// data one byte per cycle is taken, none while the checker works or a verdict is due.
// The verdict is registered once the last byte's work ends and the result slot is free.
// Reset (rst_ni low, asynchronous) clears all control state; the code-length
// table is not cleared, since only entries written in the current image are read.
`default_nettype none
module gif_stream_lzw_validator
  import gslv_pkg::*;
#(
  parameter int unsigned CODE_TABLE_ENTRIES = CodeTableEntries
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // last_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] stream_valid, [7:1] zero
);

  typedef enum logic [3:0] {
    PH_SIG, PH_GTABLE, PH_MARKER, PH_EXT_LABEL, PH_EXT_LEN, PH_EXT_DATA,
    PH_DESC, PH_LTABLE, PH_MINCODE, PH_DATA_LEN, PH_DATA, PH_TRAILER
  } phase_e;

  typedef enum logic [1:0] {T_IDLE, T_LZW, T_VERDICT} top_state_e;

  top_state_e  state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [9:0]  pcnt_q, pcnt_d;
  logic [7:0]  brem_q, brem_d;
  logic [15:0] fw_q, fw_d;
  logic [15:0] fh_q, fh_d;
  logic [31:0] pexp_q, pexp_d;
  logic        seen_q, seen_d;
  logic        failed_q, failed_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic        out_bit_q, out_bit_d;
  logic [3:0]  root_d;
  lzw_cmd_t    lzw_cmd;
  lzw_stat_t   lzw_stat;
  logic        accept;
  logic [7:0]  b;
  logic [7:0]  brem_dec;
  logic [9:0]  pcnt_dec;

  assign s_axis_tready_o = (state_q == T_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign brem_dec        = brem_q - 8'd1;
  assign pcnt_dec        = pcnt_q - 10'd1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_bit_q};

  // Parse one byte per request; hand image data to the LZW checker.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pcnt_d      = pcnt_q;
    brem_d      = brem_q;
    fw_d        = fw_q;
    fh_d        = fh_q;
    pexp_d      = pexp_q;
    seen_d      = seen_q;
    failed_d    = failed_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_bit_d   = out_bit_q;
    root_d      = b[3:0];
    lzw_cmd     = '{init: 1'b0, start: 1'b0, data: b};

    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          last_d  = s_axis_tlast_i;
          state_d = s_axis_tlast_i ? T_VERDICT : T_IDLE;
          if (!failed_q) begin
            unique case (phase_q)
              PH_SIG: begin
                if (pcnt_q < 10'd6 && b != sig_byte(pcnt_q[2:0]) &&
                    !(pcnt_q == 10'd4 && b == Gif89VerByte)) begin
                  failed_d = 1'b1;
                end else if (pcnt_q == 10'd12) begin
                  brem_d = '0;
                  if (brem_q[7]) begin
                    pcnt_d  = table_bytes(brem_q);
                    phase_d = PH_GTABLE;
                  end else begin
                    pcnt_d  = '0;
                    phase_d = PH_MARKER;
                  end
                end else begin
                  if (pcnt_q == 10'd10) brem_d = b;
                  pcnt_d = pcnt_q + 10'd1;
                end
              end
              PH_GTABLE, PH_LTABLE: begin
                pcnt_d = pcnt_dec;
                if (pcnt_dec == '0) begin
                  phase_d = (phase_q == PH_GTABLE) ? PH_MARKER : PH_MINCODE;
                end
              end
              PH_MARKER: begin
                priority if (b == TrailerByte) begin
                  if (s_axis_tlast_i && seen_q) phase_d = PH_TRAILER;
                  else failed_d = 1'b1;
                end else if (b == ExtIntroByte) begin
                  phase_d = PH_EXT_LABEL;
                end else if (b == ImageSepByte) begin
                  phase_d = PH_DESC;
                  pcnt_d  = '0;
                end else begin
                  failed_d = 1'b1;
                end
              end
              PH_EXT_LABEL: phase_d = PH_EXT_LEN;
              PH_EXT_LEN, PH_DATA_LEN: begin
                if (b == 8'd0) begin
                  if (phase_q == PH_DATA_LEN && lzw_stat.status != LZW_OK) begin
                    failed_d = 1'b1;
                  end else begin
                    if (phase_q == PH_DATA_LEN) seen_d = 1'b1;
                    phase_d = PH_MARKER;
                  end
                end else begin
                  brem_d  = b;
                  phase_d = (phase_q == PH_EXT_LEN) ? PH_EXT_DATA : PH_DATA;
                end
              end
              PH_EXT_DATA, PH_DATA: begin
                if (phase_q == PH_DATA) begin
                  lzw_cmd.start = 1'b1;
                  state_d       = T_LZW;
                end
                brem_d = brem_dec;
                if (brem_dec == '0) begin
                  phase_d = (phase_q == PH_EXT_DATA) ? PH_EXT_LEN : PH_DATA_LEN;
                end
              end
              PH_DESC: begin
                if (pcnt_q == 10'd4) fw_d = {8'd0, b};
                if (pcnt_q == 10'd5) fw_d = {b, fw_q[7:0]};
                if (pcnt_q == 10'd6) fh_d = {8'd0, b};
                if (pcnt_q == 10'd7) fh_d = {b, fh_q[7:0]};
                if (pcnt_q == 10'd8) begin
                  if (fw_q == '0 || fh_q == '0) begin
                    failed_d = 1'b1;
                  end else begin
                    pexp_d = fw_q * fh_q;
                    if (b[7]) begin
                      pcnt_d  = table_bytes(b);
                      phase_d = PH_LTABLE;
                    end else begin
                      pcnt_d  = '0;
                      phase_d = PH_MINCODE;
                    end
                  end
                end else begin
                  pcnt_d = pcnt_q + 10'd1;
                end
              end
              PH_MINCODE: begin
                if (b < 8'd2 || b > 8'd8) begin
                  failed_d = 1'b1;
                end else begin
                  lzw_cmd.init = 1'b1;
                  phase_d      = PH_DATA_LEN;
                end
              end
              default: failed_d = 1'b1;
            endcase
          end
        end
      end
      T_LZW: begin
        // wait for the checker to drain the byte
        if (!lzw_stat.busy) begin
          if (lzw_stat.status == LZW_FAILED) failed_d = 1'b1;
          state_d = last_q ? T_VERDICT : T_IDLE;
        end
      end
      T_VERDICT: begin
        // hold until the result slot frees, then restart for the next file
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_bit_d   = !failed_q && (phase_q == PH_TRAILER);
          state_d     = T_IDLE;
          phase_d     = PH_SIG;
          pcnt_d      = '0;
          brem_d      = '0;
          fw_d        = '0;
          fh_d        = '0;
          pexp_d      = '0;
          seen_d      = 1'b0;
          failed_d    = 1'b0;
          last_d      = 1'b0;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      phase_q     <= PH_SIG;
      pcnt_q      <= '0;
      brem_q      <= '0;
      fw_q        <= '0;
      fh_q        <= '0;
      pexp_q      <= '0;
      seen_q      <= 1'b0;
      failed_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pcnt_q      <= pcnt_d;
      brem_q      <= brem_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
      pexp_q      <= pexp_d;
      seen_q      <= seen_d;
      failed_q    <= failed_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_bit_q   <= out_bit_d;
    end
  end

  gslv_lzw #(
    .CODE_TABLE_ENTRIES(CODE_TABLE_ENTRIES)
  ) u_lzw (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (lzw_cmd),
    .root_bits_i    (root_d),
    .pix_expected_i (pexp_q),
    .stat_o         (lzw_stat)
  );

endmodule
`default_nettype wire

### verif/gif_stream_lzw_validator_test.sv
// Testbench for gif_stream_lzw_validator: builds GIF files byte by byte and predicts the verdict.
// Depends on gslv_pkg and gif_stream_lzw_validator; checks every verdict against its own predictor.
`default_nettype none
module gif_stream_lzw_validator_test;
  import gslv_pkg::*;

  localparam logic [7:0] ColorTableFlag = 8'h80;
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned HoldCycles    = 400;

  typedef enum logic [3:0] {
    PH_SIG, PH_GTABLE, PH_MARKER, PH_EXT_LABEL, PH_EXT_LEN, PH_EXT_DATA,
    PH_DESC, PH_LTABLE, PH_MINCODE, PH_DATA_LEN, PH_DATA, PH_TRAILER
  } gif_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  gif_stream_lzw_validator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [7:0] data_byte
    .s_axis_tlast_i (s_tlast),   // last_byte
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)    // [0] stream_valid, [7:1] zero
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor: mirrors the parser and the LZW length tracker
  // ---------------------------------------------------------------------------
  gif_phase_e  ph;
  int unsigned pcount, blk_left, fw, fh, px_exp, px_cnt, bitbuf, bitcnt;
  int unsigned root_bits, cwidth, nfree, prev_code;
  bit          prev_ok, img_seen, failed;
  lzw_status_e lstat;
  logic [15:0] seq_len [CodeTableEntries];
  logic [7:0]  sig_ref [6] = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61};

  bit verdict_q[$];   // expected stream_valid, oldest first
  bit any_fail = 1'b0;
  bit hold_rx = 1'b0; // request a long receiver hold-off
  bit idle_on = 1'b1; // random gaps on both sides

  function automatic void gif_reset();
    ph = PH_SIG; pcount = 0; blk_left = 0; fw = 0; fh = 0; px_exp = 0; px_cnt = 0;
    bitbuf = 0; bitcnt = 0; root_bits = 0; cwidth = 0; nfree = 0; prev_code = 0;
    prev_ok = 0; img_seen = 0; failed = 0; lstat = LZW_RUNNING;
    foreach (seq_len[i]) seq_len[i] = '0;
  endfunction

  function automatic int unsigned seq_length(int unsigned c);
    if (c < (1 << (root_bits & 15))) return 1;
    return seq_len[c % CodeTableEntries];
  endfunction

  function automatic void lzw_abort();
    lstat = LZW_FAILED;
    failed = 1;
  endfunction

  function automatic void lzw_take_code(int unsigned code);
    int unsigned clr, len, plen;
    clr = 1 << (root_bits & 15);
    if (code == clr) begin
      nfree = clr + 2; cwidth = root_bits + 1; prev_ok = 0;
      return;
    end
    if (code == clr + 1) begin
      lstat = (px_cnt == px_exp) ? LZW_OK : LZW_FAILED;
      if (lstat == LZW_FAILED) failed = 1;
      return;
    end
    if (code < nfree) len = seq_length(code);
    else if (code == nfree && prev_ok) begin
      plen = seq_length(prev_code);
      if (plen >= MaxSeqLen) begin lzw_abort(); return; end
      len = plen + 1;
    end else begin
      lzw_abort();
      return;
    end
    if (len > px_exp - px_cnt) begin lzw_abort(); return; end
    px_cnt += len;
    if (prev_ok && nfree < CodeTableEntries) begin
      plen = seq_length(prev_code);
      if (plen >= MaxSeqLen) begin lzw_abort(); return; end
      seq_len[nfree % CodeTableEntries] = 16'(plen + 1);
      nfree++;
      if (cwidth < MaxCodeWidth && nfree == (1 << cwidth)) cwidth++;
    end
    prev_code = code & 12'hfff;
    prev_ok = 1;
  endfunction

  function automatic void lzw_take_byte(int unsigned b);
    int unsigned code;
    if (lstat != LZW_RUNNING) return;
    bitbuf |= b << bitcnt;
    bitcnt += 8;
    while (lstat == LZW_RUNNING && bitcnt >= cwidth) begin
      code = bitbuf & ((1 << cwidth) - 1);
      bitbuf >>= cwidth;
      bitcnt -= cwidth;
      lzw_take_code(code);
    end
    bitbuf &= 20'hfffff;
  endfunction

  function automatic void parse_byte(int unsigned b, bit last);
    int unsigned flags;
    case (ph)
      PH_SIG: begin
        if (pcount < 6 && !(b == sig_ref[pcount] || (pcount == 4 && b == Gif89VerByte))) begin
          failed = 1;
          return;
        end
        if (pcount == 10) blk_left = b;
        if (pcount == 12) begin
          flags = blk_left; blk_left = 0; pcount = 0;
          if (flags & ColorTableFlag) begin
            pcount = 3 * (2 << (flags & 7));
            ph = PH_GTABLE;
          end else ph = PH_MARKER;
          return;
        end
        pcount++;
      end
      PH_GTABLE, PH_LTABLE: begin
        pcount--;
        if (pcount == 0) ph = (ph == PH_GTABLE) ? PH_MARKER : PH_MINCODE;
      end
      PH_MARKER: begin
        if (b == TrailerByte) begin
          if (last && img_seen) ph = PH_TRAILER;
          else failed = 1;
        end else if (b == ExtIntroByte) ph = PH_EXT_LABEL;
        else if (b == ImageSepByte) begin
          ph = PH_DESC; pcount = 0;
        end else failed = 1;
      end
      PH_EXT_LABEL: ph = PH_EXT_LEN;
      PH_EXT_LEN, PH_DATA_LEN: begin
        if (b == 0) begin
          if (ph == PH_DATA_LEN) begin
            if (lstat != LZW_OK) begin failed = 1; return; end
            img_seen = 1;
          end
          ph = PH_MARKER;
        end else begin
          blk_left = b;
          ph = (ph == PH_EXT_LEN) ? PH_EXT_DATA : PH_DATA;
        end
      end
      PH_EXT_DATA, PH_DATA: begin
        if (ph == PH_DATA) lzw_take_byte(b);
        blk_left = (blk_left - 1) & 8'hff;
        if (blk_left == 0) ph = (ph == PH_EXT_DATA) ? PH_EXT_LEN : PH_DATA_LEN;
      end
      PH_DESC: begin
        if (pcount == 4) fw = b;
        if (pcount == 5) fw |= b << 8;
        if (pcount == 6) fh = b;
        if (pcount == 7) fh |= b << 8;
        if (pcount == 8) begin
          if (fw == 0 || fh == 0) begin failed = 1; return; end
          px_exp = fw * fh; pcount = 0;
          if (b & ColorTableFlag) begin
            pcount = 3 * (2 << (b & 7));
            ph = PH_LTABLE;
          end else ph = PH_MINCODE;
          return;
        end
        pcount++;
      end
      PH_MINCODE: begin
        if (b < 2 || b > 8) begin failed = 1; return; end
        root_bits = b; cwidth = b + 1; nfree = (1 << b) + 2;
        prev_code = 0; prev_ok = 0; px_cnt = 0; bitbuf = 0; bitcnt = 0;
        lstat = LZW_RUNNING;
        ph = PH_DATA_LEN;
      end
      default: failed = 1;
    endcase
  endfunction

  // Advance the predictor by one accepted byte; queue a verdict on the last one
  function automatic void predict_byte(logic [7:0] b, bit last);
    if (!failed) parse_byte(b, last);
    if (last) begin
      verdict_q.push_back(!failed && ph == PH_TRAILER);
      gif_reset();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  int unsigned bytes_sent = 0;

  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // Hold the sender until every expected verdict has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // GIF file builder
  // ---------------------------------------------------------------------------
  logic [7:0]  file_q[$];
  int unsigned gen_len [CodeTableEntries];

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  task automatic put_header(bit v89, bit gct);
    logic [7:0] flags;
    file_q = {8'h47, 8'h49, 8'h46, 8'h38, v89 ? 8'h39 : 8'h37, 8'h61};
    repeat (4) file_q.push_back($urandom);
    flags = $urandom_range(0, 255);
    flags[7] = gct;
    if (gct) flags[2:0] = $urandom_range(0, 2);
    file_q.push_back(flags);
    repeat (2) file_q.push_back($urandom);
    if (gct) repeat (3 * (2 << flags[2:0])) file_q.push_back($urandom);
  endtask

  // Split a payload into sub-blocks and close with the zero-length block
  task automatic put_blocks(ref logic [7:0] pay[$], input bit big);
    int unsigned n;
    while (pay.size() != 0) begin
      n = $urandom_range(1, big ? 255 : 12);
      if (n > pay.size()) n = pay.size();
      file_q.push_back(n);
      repeat (n) file_q.push_back(pay.pop_front());
    end
    file_q.push_back(8'h00);
  endtask

  task automatic put_ext();
    logic [7:0] pay[$];
    file_q.push_back(ExtIntroByte);
    file_q.push_back($urandom);
    repeat ($urandom_range(0, 20)) pay.push_back($urandom);
    put_blocks(pay, 1'b0);
  endtask

  // Emit an image whose LZW stream covers exactly w * h pixels (end code omitted on skip_end)
  task automatic put_image(int unsigned w, int unsigned h, int unsigned mincode, bit lct,
                           bit roots_only, bit junk, bit skip_end);
    logic [7:0]  pay[$];
    logic [7:0]  flags;
    int unsigned clr, nf, cw, rem, acc, nb, code, len, prev, pick, c;
    bit          pv;
    file_q.push_back(ImageSepByte);
    repeat (4) file_q.push_back($urandom);
    file_q.push_back(w[7:0]); file_q.push_back(w[15:8]);
    file_q.push_back(h[7:0]); file_q.push_back(h[15:8]);
    flags = $urandom_range(0, 255);
    flags[7] = lct;
    if (lct) flags[2:0] = $urandom_range(0, 1);
    file_q.push_back(flags);
    if (lct) repeat (3 * (2 << flags[2:0])) file_q.push_back($urandom);
    file_q.push_back(mincode);
    if (w * h == 0) return;
    clr = 1 << mincode; nf = clr + 2; cw = mincode + 1; rem = w * h;
    acc = 0; nb = 0; pv = 0; prev = 0;
    for (int k = 0; k < 2; k++) begin
      while ((k == 0) ? rem > 0 : !skip_end) begin
        code = (k == 1) ? clr + 1 : $urandom_range(0, clr - 1);
        len = 1;
        pick = roots_only ? 7 : $urandom_range(0, 7);
        if (k == 0 && (($urandom_range(0, 59) == 0 && !roots_only) ||
                       (acc == 0 && nb == 0 && $urandom_range(0, 1)))) code = clr;
        else if (k == 0 && pick == 0 && pv && nf < CodeTableEntries &&
                 (prev < clr ? 1 : gen_len[prev]) + 1 <= rem) begin
          code = nf; len = (prev < clr ? 1 : gen_len[prev]) + 1;
        end else if (k == 0 && pick < 4 && nf > clr + 2) begin
          c = $urandom_range(clr + 2, nf - 1);
          if (gen_len[c] <= rem) begin code = c; len = gen_len[c]; end
        end
        acc |= code << nb;
        nb += cw;
        while (nb >= 8) begin pay.push_back(acc[7:0]); acc >>= 8; nb -= 8; end
        if (k == 1) break;
        if (code == clr) begin
          nf = clr + 2; cw = mincode + 1; pv = 0;
          continue;
        end
        rem -= len;
        if (pv && nf < CodeTableEntries) begin
          gen_len[nf] = (prev < clr ? 1 : gen_len[prev]) + 1;
          nf++;
          if (cw < MaxCodeWidth && nf == (1 << cw)) cw++;
        end
        prev = code; pv = 1;
      end
    end
    if (nb > 0) pay.push_back(acc[7:0]);
    if (junk) repeat ($urandom_range(1, 4)) pay.push_back($urandom);
    put_blocks(pay, roots_only);
  endtask

  task automatic put_small_image();
    put_image($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(2, 8),
              $urandom_range(0, 3) == 0, 1'b0, $urandom_range(0, 5) == 0, 1'b0);
  endtask

  task automatic build_random_file();
    int unsigned k;
    put_header($urandom_range(0, 1), $urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 2) == 0) put_ext();
      put_small_image();
    end
    file_q.push_back(TrailerByte);
    // Corrupt a share of the files: bad byte, cut short, bytes after the trailer, or all random
    case ($urandom_range(0, 11))
      0: begin k = $urandom_range(0, file_q.size() - 1); file_q[k] = $urandom; end
      1: repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
      2: file_q.push_back($urandom);
      3: begin
        file_q.delete();
        repeat ($urandom_range(1, 20)) file_q.push_back($urandom);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready generator, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin : rx_ready
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      n = idle_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict stream_valid=%0b", m_tdata[0]);
        any_fail = 1'b1;
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want) begin
          $error("stream_valid: expected %0b, actual %0b", want, m_tdata[0]);
          any_fail = 1'b1;
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // Minimal valid files, both versions, with tables and an extension
    put_header(1'b1, 1'b0); put_image(1, 1, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    put_header(1'b0, 1'b1); put_ext(); put_image(5, 3, 8, 1'b1, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    // Bits after the end code are skipped
    put_header(1'b1, 1'b0); put_image(4, 4, 3, 1'b0, 1'b0, 1'b1, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    // Zero width, zero height
    put_header(1'b1, 1'b0); put_image(0, 4, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    put_header(1'b1, 1'b0); put_image(4, 0, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    // Minimum code size out of range, low and high
    put_header(1'b0, 1'b0); put_image(2, 2, 1, 1'b0, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    put_header(1'b0, 1'b0); put_image(2, 2, 9, 1'b0, 1'b0, 1'b0, 1'b0);
    file_q.push_back(TrailerByte); send_file();
    // Image data closed without an end code
    put_header(1'b1, 1'b0); put_image(3, 3, 2, 1'b0, 1'b0, 1'b0, 1'b1);
    file_q.push_back(TrailerByte); send_file();
    // Trailer with no image, trailer not last, unknown marker
    put_header(1'b1, 1'b0); file_q.push_back(TrailerByte); send_file();
    put_header(1'b1, 1'b0); put_small_image(); file_q.push_back(TrailerByte);
    file_q.push_back(8'hff); send_file();
    put_header(1'b1, 1'b0); put_small_image(); file_q.push_back(8'h00);
    file_q.push_back(TrailerByte); send_file();
    // Bad signature, and a file cut short inside the header
    put_header(1'b1, 1'b0); file_q[1] = 8'h00; put_small_image();
    file_q.push_back(TrailerByte); send_file();
    file_q = {8'h47, 8'h49, 8'h46};
    send_file();
    drain();
  endtask

  // Roots only, enough codes to fill the table and run at width 12
  task automatic test_full_table();
    put_header(1'b1, 1'b0);
    put_image(70, 64, 2, 1'b0, 1'b1, 1'b0, 1'b0);
    file_q.push_back(TrailerByte);
    send_file();
    drain();
  endtask

  // Hold the result side off while the sender keeps pushing files
  task automatic test_backpressure();
    hold_rx = 1'b1;
    repeat (4) begin
      put_header(1'b0, 1'b0); put_small_image(); file_q.push_back(TrailerByte);
      send_file();
    end
    drain();
  endtask

  task automatic test_random();
    int unsigned files, start;
    files = 0;
    start = bytes_sent;
    while (bytes_sent - start < 500 || files < 40) begin
      if (files % 10 == 0) idle_on = ($urandom_range(0, 3) != 0);
      build_random_file();
      send_file();
      files++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int unsigned waited;
    gif_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < StallLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (!any_fail && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
